>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the start-code scanner modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define NALSC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define NALSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define NALSC_ASSERT_IMPL(lbl, ante, cons, msg)
`define NALSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/nalsc_pkg.sv
// Package: constants and command type of the start-code scanner
package nalsc_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int MARK_W      = OFFSET_BITS + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] KIND_MASK  = 8'h1f;
	localparam logic [7:0] PRIO_MASK  = 8'h60;
	localparam int         PRIO_SHIFT = 5;
	localparam logic [7:0] CODE_BYTE  = 8'h01;

	typedef struct packed {
		logic                hdr;
		logic [7:0]          hdr_byte;
		logic                start;
		logic                eos;
		logic [MARK_W-1:0]   mark;
		logic                sat;
	} cmd_t;

endpackage

>>> hw/rtl/nalsc_byte_if.sv
// Interface: input byte channel
interface nalsc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_stream;

	modport source (output valid, data_byte, end_of_stream, input ready);
	modport sink (input valid, data_byte, end_of_stream, output ready);
endinterface

>>> hw/rtl/nalsc_unit_if.sv
// Interface: unit record channel
interface nalsc_unit_if;
	logic        valid;
	logic        ready;
	logic [31:0] unit_index;
	logic [31:0] unit_offset;
	logic [31:0] unit_length;
	logic [4:0]  unit_kind;
	logic [1:0]  ref_priority;
	logic        closed_by_end;
	logic        offset_overflow;

	modport source (output valid, unit_index, unit_offset, unit_length, unit_kind,
		ref_priority, closed_by_end, offset_overflow, input ready);
	modport sink (input valid, unit_index, unit_offset, unit_length, unit_kind,
		ref_priority, closed_by_end, offset_overflow, output ready);
endinterface

>>> hw/rtl/nalsc_front.sv
// Front end: byte tracking, start-code detection and command issue
`include "assert_macros.svh"

module nalsc_front (
	input  logic             clk,
	input  logic             arst_n,
	nalsc_byte_if.sink       stream,
	output nalsc_pkg::cmd_t  cmd,
	output logic             cmd_push,
	input  logic             cmd_ready
);
	import nalsc_pkg::*;

	localparam logic [OFFSET_BITS-1:0] POS_MAX  = '1;
	localparam logic [OFFSET_BITS-1:0] POS_ONE  = OFFSET_BITS'(1);
	localparam logic [OFFSET_BITS-1:0] BACK_TWO = OFFSET_BITS'(2);
	localparam logic [OFFSET_BITS-1:0] BACK_THR = OFFSET_BITS'(3);
	localparam logic [1:0]             ZR_MAX   = 2'd3;

	logic [1:0]             zr_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic                   hdr_q;
	logic                   sat_q;

	logic                   accept;
	logic                   is_start;
	logic                   sat_n;
	logic [OFFSET_BITS-1:0] pos_n;
	logic [OFFSET_BITS-1:0] start_pos;
	logic [1:0]             zr_n;

	assign stream.ready = cmd_ready;
	assign accept       = stream.valid && stream.ready;

	always_comb begin
		is_start  = (stream.data_byte == CODE_BYTE) && (zr_q >= 2'd2) && !stream.end_of_stream;
		sat_n     = sat_q || (pos_q >= POS_MAX - POS_ONE);
		pos_n     = (pos_q == POS_MAX) ? pos_q : pos_q + POS_ONE;
		start_pos = pos_q - ((zr_q == ZR_MAX) ? BACK_THR : BACK_TWO);
		if (stream.data_byte == 8'h00) begin
			zr_n = (zr_q == ZR_MAX) ? ZR_MAX : zr_q + 2'd1;
		end else begin
			zr_n = 2'd0;
		end
		cmd.hdr      = hdr_q;
		cmd.hdr_byte = stream.data_byte;
		cmd.start    = is_start;
		cmd.eos      = stream.end_of_stream;
		cmd.sat      = sat_n;
		cmd.mark     = is_start ? {1'b0, start_pos} : ({1'b0, pos_q} + MARK_W'(1));
		cmd_push     = accept && (hdr_q || is_start || stream.end_of_stream);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zr_q  <= 2'd0;
			pos_q <= '0;
			hdr_q <= 1'b0;
			sat_q <= 1'b0;
		end else if (accept) begin
			if (stream.end_of_stream) begin
				zr_q  <= 2'd0;
				pos_q <= '0;
				hdr_q <= 1'b0;
				sat_q <= 1'b0;
			end else begin
				zr_q  <= zr_n;
				pos_q <= pos_n;
				hdr_q <= is_start;
				sat_q <= sat_n;
			end
		end
	end

	`NALSC_ASSERT_NEXT(a_eos_clears, accept && stream.end_of_stream, pos_q == '0 && zr_q == 2'd0 && !hdr_q, "front state not cleared after end of stream")
	`NALSC_ASSERT_NEXT(a_pos_step, accept && !stream.end_of_stream && pos_q != POS_MAX, pos_q == $past(pos_q) + POS_ONE, "byte position did not advance")
endmodule

>>> hw/rtl/nalsc_queue.sv
// Command queue between front end and back end
`include "assert_macros.svh"

module nalsc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  nalsc_pkg::cmd_t  wr_cmd,
	input  logic             push,
	output logic             not_full,
	output nalsc_pkg::cmd_t  rd_cmd,
	output logic             not_empty,
	input  logic             pop
);
	import nalsc_pkg::*;

	localparam logic [QUEUE_AW-1:0] LAST_PTR = QUEUE_AW'(QUEUE_DEPTH - 1);
	localparam logic [QUEUE_CW-1:0] FULL_CNT = QUEUE_CW'(QUEUE_DEPTH);

	cmd_t                slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wptr_q;
	logic [QUEUE_AW-1:0] rptr_q;
	logic [QUEUE_CW-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign not_full  = cnt_q != FULL_CNT;
	assign not_empty = cnt_q != '0;
	assign rd_cmd    = slot_q[rptr_q];
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == LAST_PTR) ? '0 : wptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == LAST_PTR) ? '0 : rptr_q + QUEUE_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QUEUE_CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QUEUE_CW'(1);
			end
		end
	end

	`NALSC_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= FULL_CNT, "queue count beyond depth")
	`NALSC_ASSERT_NEXT(a_pop_count, do_pop && !do_push, cnt_q == $past(cnt_q) - QUEUE_CW'(1), "queue count wrong after pop")
endmodule

>>> hw/rtl/nalsc_back.sv
// Back end: open-unit tracking and record output register
`include "assert_macros.svh"

module nalsc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  nalsc_pkg::cmd_t  cmd,
	input  logic             cmd_valid,
	output logic             cmd_pop,
	nalsc_unit_if.source     units
);
	import nalsc_pkg::*;

	logic                   active_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [4:0]             kind_q;
	logic [1:0]             prio_q;
	logic [31:0]            seen_q;

	logic                   out_valid_q;
	logic [31:0]            index_q;
	logic [31:0]            offset_q;
	logic [31:0]            length_q;
	logic [4:0]             okind_q;
	logic [1:0]             oprio_q;
	logic                   by_end_q;
	logic                   ovf_q;

	logic [4:0]             kind_cur;
	logic [1:0]             prio_cur;
	logic [MARK_W-1:0]      len;
	logic                   emit;

	assign cmd_pop = cmd_valid && (!out_valid_q || units.ready);

	always_comb begin
		kind_cur = cmd.hdr ? 5'(cmd.hdr_byte & KIND_MASK) : kind_q;
		prio_cur = cmd.hdr ? 2'((cmd.hdr_byte & PRIO_MASK) >> PRIO_SHIFT) : prio_q;
		len      = cmd.mark - {1'b0, off_q};
		emit     = cmd_pop && active_q && (cmd.start || cmd.eos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			off_q    <= '0;
			kind_q   <= '0;
			prio_q   <= '0;
			seen_q   <= '0;
		end else if (cmd_pop) begin
			if (cmd.eos) begin
				active_q <= 1'b0;
				off_q    <= '0;
				kind_q   <= '0;
				prio_q   <= '0;
				seen_q   <= '0;
			end else if (cmd.start) begin
				active_q <= 1'b1;
				off_q    <= cmd.mark[OFFSET_BITS-1:0];
				kind_q   <= '0;
				prio_q   <= '0;
				if (emit) begin
					seen_q <= seen_q + 32'd1;
				end
			end else begin
				kind_q <= kind_cur;
				prio_q <= prio_cur;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (units.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			index_q  <= seen_q;
			offset_q <= 32'(off_q);
			length_q <= 32'(len);
			okind_q  <= kind_cur;
			oprio_q  <= prio_cur;
			by_end_q <= cmd.eos;
			ovf_q    <= cmd.sat;
		end
	end

	assign units.valid           = out_valid_q;
	assign units.unit_index      = index_q;
	assign units.unit_offset     = offset_q;
	assign units.unit_length     = length_q;
	assign units.unit_kind       = okind_q;
	assign units.ref_priority    = oprio_q;
	assign units.closed_by_end   = by_end_q;
	assign units.offset_overflow = ovf_q;

	`NALSC_ASSERT_NEXT(a_seen_count, emit && !cmd.eos, seen_q == index_q + 32'd1, "unit count out of step with emitted index")
	`NALSC_ASSERT_IMPL(a_no_overrun, emit, !out_valid_q || units.ready, "record overwritten while waiting")
endmodule

>>> hw/rtl/nal_unit_start_code_scanner_core.sv
// Top level: H.264 Annex B start-code scanner
// Scans one stream byte per cycle while the queue has room: the front end detects 3- and
// 4-byte start codes and header bytes and issues a command into a four-entry queue; the
// back end tracks the open unit and loads a record into an output register when a start
// code or the end of the stream closes it. The closing command is queued first, and the
// record is registered when the back end pops it. Every start code, header byte and
// stream end takes one queue entry. While a record waits on the output the back end
// pops nothing, so the input stalls once four such commands have queued; after a pop
// from the full queue the input accepts again on the next edge. Byte offsets saturate
// at 2^OFFSET_BITS - 1 and then set offset_overflow in every later record of the
// stream.
module nal_unit_start_code_scanner_core (
	input  logic          clk,
	input  logic          arst_n,
	nalsc_byte_if.sink    stream,
	nalsc_unit_if.source  units
);
	import nalsc_pkg::*;

	cmd_t wr_cmd;
	cmd_t rd_cmd;
	logic push;
	logic not_full;
	logic not_empty;
	logic pop;

	nalsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.cmd       (wr_cmd),
		.cmd_push  (push),
		.cmd_ready (not_full)
	);

	nalsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_cmd    (wr_cmd),
		.push      (push),
		.not_full  (not_full),
		.rd_cmd    (rd_cmd),
		.not_empty (not_empty),
		.pop       (pop)
	);

	nalsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (rd_cmd),
		.cmd_valid (not_empty),
		.cmd_pop   (pop),
		.units     (units)
	);
endmodule
